### rtl/tqr_pkg.sv
// ----------------------------------------------------------------------------
// Terrain quad refinement package
// Shared payload types, register indexes, state encodings and constants.
// ----------------------------------------------------------------------------
package tqr_pkg;

  localparam int FractionBits = 4;
  localparam logic [31:0] LcgMul   = 32'd214013;
  localparam logic [31:0] LcgAdd   = 32'd2531011;
  localparam logic [31:0] LcgReset = 32'd83838383;

  // Reciprocal of six scaled by two to the SixthShift; exact for 16-bit operands.
  localparam logic [15:0] SixthRecip = 16'd43691;
  localparam int          SixthShift = 18;

  typedef enum logic [2:0] {
    REG_PASS_MODE    = 3'd0,
    REG_ODD_VARIANT  = 3'd1,
    REG_MIN_HEIGHT   = 3'd2,
    REG_MAX_HEIGHT   = 3'd3,
    REG_MESH_DIVISOR = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_REFINE = 2'd0,
    CMD_SEED   = 2'd1
  } cmd_code_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] seed;
    logic [15:0] corner_tl;
    logic [15:0] corner_tr;
    logic [15:0] corner_bl;
    logic [15:0] corner_br;
    logic [6:0]  quad_edge;
    logic [15:0] roughness;
  } in_item_t;

  typedef struct packed {
    logic [15:0] child_tl;
    logic [15:0] child_tr;
    logic [15:0] child_bl;
    logic [15:0] child_br;
  } out_item_t;

  typedef struct packed {
    logic        pass_mode;
    logic        odd_variant;
    logic [15:0] min_height;
    logic [15:0] max_height;
    logic [15:0] mesh_divisor;
  } cfg_t;

  // Queue entry: a classified job handed from the front to the back end.
  typedef struct packed {
    logic        is_seed;
    logic [31:0] seed;
    logic [3:0][17:0] kid;
    logic [6:0]  quad_edge;
    logic [15:0] roughness;
  } job_t;

  // Divider request/response travels as a struct.
  typedef struct packed {
    logic        start;
    logic [22:0] dividend;
    logic [16:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [22:0] quot;
    logic [16:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CENTER,
    ST_CENTER_WAIT,
    ST_DRAW,
    ST_DRAW_WAIT,
    ST_SIXTH,
    ST_SIXTH_LIMIT,
    ST_FINISH,
    ST_WRAP,
    ST_WRAP_WAIT,
    ST_STORE,
    ST_OUT
  } be_state_t;

endpackage

### rtl/terrain_quad_refine_unit.sv
// ----------------------------------------------------------------------------
// Terrain quad refinement unit
// Bilinear child heights with random displacement from a 32-bit LCG.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  in_       in_valid/in_stall  in_item_t
//  out_      out_valid/out_stall out_item_t
//  cfg_      cfg_valid/cfg_ready cfg_index, cfg_data
//
// A refine transaction in the back end waits on the shared serial divider for
// each draw modulo, for the centre division in the altitude pass, and for each
// child that wraps in the odd roughness variant outside the altitude pass; a zero
// bound skips a draw modulo. The queue registers each job before the back end
// sees it; a seed transaction is taken straight from idle. Reset is synchronous
// and clears control state and the generator. A two-entry queue lets input be
// taken while the back end works, and the result register holds while out_stall
// is high.
module terrain_quad_refine_unit
  import tqr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;
  logic job_valid, job_pop, busy;
  job_t job;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PASS_MODE:    cfg_nxt.pass_mode    = cfg_data[0];
        REG_ODD_VARIANT:  cfg_nxt.odd_variant  = cfg_data[0];
        REG_MIN_HEIGHT:   cfg_nxt.min_height   = cfg_data;
        REG_MAX_HEIGHT:   cfg_nxt.max_height   = cfg_data;
        REG_MESH_DIVISOR: cfg_nxt.mesh_divisor = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{pass_mode: 1'b0, odd_variant: 1'b0, min_height: 16'd0,
                 max_height: 16'hffff, mesh_divisor: 16'd200};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tqr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .job_valid(job_valid), .job_pop(job_pop), .job(job)
  );

  tqr_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .job_valid(job_valid),
    .job_pop(job_pop), .job(job), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data), .busy(busy)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid) else $error("queue popped while empty");

  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped under stall");

  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

endmodule

### rtl/tqr_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tqr_divider
  import tqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [22:0] quot_r, quot_nxt;
  logic [17:0] rem_r, rem_nxt;
  logic [16:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[16:0], quot_r[22]};
    if (req.start) begin
      quot_nxt = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = trial - {1'b0, dvs_r};
        quot_nxt = {quot_r[21:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[21:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd22) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;
  assign rsp.rem  = rem_r[16:0];

endmodule

### rtl/tqr_front.sv
// ----------------------------------------------------------------------------
// Refinement front end
// Accepts items, forms the bilinear child heights and queues the jobs.
// ----------------------------------------------------------------------------
module tqr_front
  import tqr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     job_valid,
  input  logic     job_pop,
  output job_t     job
);

  localparam int Depth = 2;

  job_t        q_r [Depth];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push;
  job_t        jin;

  function automatic logic [17:0] blend(input logic [15:0] w9, input logic [15:0] w3a,
                                        input logic [15:0] w3b, input logic [15:0] w1);
    logic [19:0] s;
    s = {w9, 3'b000} + {4'd0, w9} + {w3a, 1'b0} + {4'd0, w3a}
      + {w3b, 1'b0} + {4'd0, w3b} + {4'd0, w1};
    return {2'b00, s[19:4]};
  endfunction

  always_comb begin
    jin.is_seed     = in_data.cmd;
    jin.seed        = in_data.seed;
    jin.quad_edge   = in_data.quad_edge;
    jin.roughness   = in_data.roughness;
    jin.kid[0] = blend(in_data.corner_tl, in_data.corner_tr, in_data.corner_bl, in_data.corner_br);
    jin.kid[1] = blend(in_data.corner_tr, in_data.corner_tl, in_data.corner_br, in_data.corner_bl);
    jin.kid[2] = blend(in_data.corner_bl, in_data.corner_tl, in_data.corner_br, in_data.corner_tr);
    jin.kid[3] = blend(in_data.corner_br, in_data.corner_tr, in_data.corner_bl, in_data.corner_tl);
  end

  assign in_stall  = (cnt_r == 2'(Depth));
  assign push      = in_valid && !in_stall;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (job_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(job_pop);
    end
    if (push) q_r[wp_r] <= jin;
  end

endmodule

### rtl/tqr_back.sv
// ----------------------------------------------------------------------------
// Refinement back end
// Runs the generator, the displacement draws and the clamp or wrap per child.
// ----------------------------------------------------------------------------
module tqr_back
  import tqr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      job_valid,
  output logic      job_pop,
  input  job_t      job,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic      busy
);

  be_state_t   state_r, state_nxt;
  logic [31:0] lcg_r, lcg_nxt;
  logic [22:0] center_r, center_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic signed [25:0] p_r, p_nxt;
  logic [3:0][15:0] res_r, res_nxt;
  logic        ov_r, ov_nxt;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [31:0] lcg_step;
  logic [14:0] rnd15;
  logic [23:0] bound;
  logic [22:0] rprod;
  logic signed [25:0] lo, hi, q, tmp;
  logic [24:0] wrap_num;
  logic [15:0] sixth_mag;
  logic [31:0] sixth_prod;

  tqr_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign lcg_step = lcg_r * LcgMul + LcgAdd;
  assign rnd15    = lcg_step[30:16];
  assign rprod    = 23'(job.quad_edge) * 23'(job.roughness);
  assign bound    = (cfg.pass_mode && !cfg.odd_variant) || (cfg.pass_mode)
                    ? {center_r, 1'b0}
                    : (cfg.odd_variant ? {1'b0, center_r} : {center_r, 1'b0});
  assign lo = 26'(cfg.min_height);
  assign hi = 26'(cfg.max_height);
  assign busy = (state_r != ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_data  = {res_r[0], res_r[1], res_r[2], res_r[3]};

  always_comb begin
    state_nxt  = state_r;
    lcg_nxt    = lcg_r;
    center_nxt = center_r;
    kidx_nxt   = kidx_r;
    p_nxt      = p_r;
    res_nxt    = res_r;
    ov_nxt     = ov_r && out_stall;
    job_pop    = 1'b0;
    dreq       = '0;
    q          = '0;
    tmp        = '0;
    wrap_num   = '0;
    sixth_mag  = '0;
    sixth_prod = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          if (job.is_seed) begin
            lcg_nxt = job.seed;
            job_pop = 1'b1;
          end else if (!ov_r || !out_stall) begin
            kidx_nxt  = 2'd0;
            state_nxt = ST_CENTER;
          end
        end
      end
      ST_CENTER: begin
        if (!cfg.pass_mode) begin
          center_nxt = 23'({job.quad_edge, FractionBits'(0)});
          state_nxt  = ST_DRAW;
        end else if (cfg.mesh_divisor == 16'd0) begin
          center_nxt = '0;
          state_nxt  = ST_DRAW;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = rprod;
          dreq.divisor  = {1'b0, cfg.mesh_divisor};
          state_nxt     = ST_CENTER_WAIT;
        end
      end
      ST_CENTER_WAIT: begin
        if (drsp.done) begin
          center_nxt = drsp.quot;
          state_nxt  = ST_DRAW;
        end
      end
      ST_DRAW: begin
        lcg_nxt = lcg_step;
        p_nxt   = 26'(job.kid[kidx_r]);
        if (bound == 24'd0) begin
          state_nxt = ST_SIXTH;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = 23'(rnd15);
          dreq.divisor  = bound[16:0];
          if (bound > 24'd32767) dreq.divisor = 17'h1ffff;
          state_nxt     = ST_DRAW_WAIT;
        end
      end
      ST_DRAW_WAIT: begin
        if (drsp.done) begin
          p_nxt     = p_r + 26'(drsp.rem);
          state_nxt = ST_SIXTH;
        end
      end
      ST_SIXTH: begin
        // The sixth of (max - kid) truncates toward zero, so divide the magnitude.
        if (!cfg.pass_mode && cfg.odd_variant) begin
          tmp        = hi - 26'(job.kid[kidx_r]);
          sixth_mag  = tmp[25] ? 16'(-tmp) : 16'(tmp);
          sixth_prod = 32'(sixth_mag) * 32'(SixthRecip);
          q          = tmp[25] ? -26'(sixth_prod >> SixthShift)
                               : 26'(sixth_prod >> SixthShift);
          p_nxt      = p_r + 26'({center_r, 1'b0}) - q;
          state_nxt  = ST_SIXTH_LIMIT;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SIXTH_LIMIT: begin
        if (p_r < lo) begin
          p_nxt     = p_r + lo + 26'd1;
          state_nxt = ST_STORE;
        end else if (p_r > hi) begin
          state_nxt = ST_WRAP;
        end else begin
          state_nxt = ST_STORE;
        end
      end
      ST_WRAP: begin
        wrap_num      = 25'(p_r);
        dreq.start    = 1'b1;
        dreq.dividend = wrap_num[22:0];
        dreq.divisor  = 17'(hi) + 17'd1;
        state_nxt     = ST_WRAP_WAIT;
      end
      ST_WRAP_WAIT: begin
        if (drsp.done) begin
          p_nxt     = 26'(drsp.rem);
          state_nxt = ST_STORE;
        end
      end
      ST_FINISH: begin
        p_nxt = p_r - 26'(center_r);
        if (cfg.odd_variant) begin
          tmp   = 26'(job.kid[kidx_r]);
          p_nxt = p_nxt + (tmp >>> 2);
          if (p_nxt < lo) p_nxt = lo;
          else if (p_nxt > hi) p_nxt = p_nxt - hi - 26'd1;
        end else begin
          if (p_nxt < lo) p_nxt = lo;
          else if (p_nxt > hi) p_nxt = hi;
        end
        state_nxt = ST_STORE;
      end
      ST_STORE: begin
        res_nxt[kidx_r] = p_r[15:0];
        kidx_nxt = kidx_r + 2'd1;
        if (kidx_r == 2'd3) state_nxt = ST_OUT;
        else state_nxt = ST_DRAW;
      end
      ST_OUT: begin
        ov_nxt    = 1'b1;
        job_pop   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      lcg_r   <= LcgReset;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lcg_r   <= lcg_nxt;
      ov_r    <= ov_nxt;
    end
    center_r <= center_nxt;
    kidx_r   <= kidx_nxt;
    p_r      <= p_nxt;
    res_r    <= res_nxt;
  end

endmodule

### tb/tb_terrain_quad_refine_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Terrain quad refinement unit testbench
// Drives directed and random quads and seed loads through the valid/stall
// channels, and checks each result against a set value or a local predictor of
// the kernel, the generator and the clamp or wrap rules in every pass and variant.
// ----------------------------------------------------------------------------
module tb_terrain_quad_refine_unit;
  import tqr_pkg::*;

  localparam int IdleLimit  = 20000;
  localparam int DrainWait  = 400;
  localparam int PhaseItems = 196;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t result;
  } quad_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [2:0] cfg_index;
  logic [15:0] cfg_data;

  // Predictor state: generator and register mirror.
  logic [31:0] gen_state;
  logic        m_pass;
  logic        m_odd;
  logic [15:0] m_min;
  logic [15:0] m_max;
  logic [15:0] m_div;

  out_item_t   child_q[$];
  int          err_count;
  int          idle_cycles;
  bit          quiet;

  terrain_quad_refine_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint lcg_draw(longint bound);
    logic [31:0] s;
    s = gen_state * LcgMul + LcgAdd;
    gen_state = s;
    if (bound <= 0) return 0;
    return longint'({17'd0, s[30:16]}) % bound;
  endfunction

  function automatic longint displace(longint p, longint centre);
    longint range;
    longint lo;
    longint hi;
    range = centre * 2;
    lo = longint'(m_min);
    hi = longint'(m_max);
    if (!m_pass && m_odd) begin
      p = p + lcg_draw(centre) + range - (hi - p) / 6;
      if (p < lo) p = p + lo + 1;
      else if (p > hi) p = p % (hi + 1);
    end else if (m_pass && m_odd) begin
      p = p + lcg_draw(range) - centre + p / 4;
      if (p < lo) p = lo;
      else if (p > hi) p = p - (hi + 1);
    end else begin
      p = p + lcg_draw(range) - centre;
      if (p < lo) p = lo;
      else if (p > hi) p = hi;
    end
    return p;
  endfunction

  function automatic out_item_t refine_quad(in_item_t it);
    longint a, b, c, d, sq, centre;
    longint kid[4];
    out_item_t r;
    a = it.corner_tl;
    b = it.corner_tr;
    c = it.corner_bl;
    d = it.corner_br;
    sq = it.quad_edge;
    kid[0] = (9 * a + 3 * b + 3 * c + d) >>> 4;
    kid[1] = (3 * a + 9 * b + c + 3 * d) >>> 4;
    kid[2] = (3 * a + b + 9 * c + 3 * d) >>> 4;
    kid[3] = (a + 3 * b + 3 * c + 9 * d) >>> 4;
    if (!m_pass) centre = sq << FractionBits;
    else if (m_div == 16'd0) centre = 0;
    else centre = (sq * longint'(it.roughness)) / longint'(m_div);
    // Draw order is tl, tr, bl, br.
    r.child_tl = 16'(displace(kid[0], centre));
    r.child_tr = 16'(displace(kid[1], centre));
    r.child_bl = 16'(displace(kid[2], centre));
    r.child_br = 16'(displace(kid[3], centre));
    return r;
  endfunction

  function automatic in_item_t make_quad(logic cmd, logic [31:0] seed, logic [15:0] tl,
                                         logic [15:0] tr, logic [15:0] bl, logic [15:0] br,
                                         logic [6:0] sq, logic [15:0] rough);
    in_item_t it;
    it.cmd = cmd;
    it.seed = seed;
    it.corner_tl = tl;
    it.corner_tr = tr;
    it.corner_bl = bl;
    it.corner_br = br;
    it.quad_edge = sq;
    it.roughness = rough;
    return it;
  endfunction

  function automatic logic [15:0] rand_height();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'h0000;
    if (sel == 1) return 16'hffff;
    return 16'($urandom);
  endfunction

  function automatic in_item_t rand_quad();
    in_item_t it;
    logic [6:0] sq;
    if ($urandom_range(99) < 80) sq = 7'(1 << $urandom_range(6));
    else sq = 7'($urandom_range(127));
    it = make_quad(1'(CMD_REFINE), $urandom, rand_height(), rand_height(), rand_height(),
                   rand_height(), sq, 16'($urandom));
    if ($urandom_range(99) < 6) it.cmd = 1'(CMD_SEED);
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  task automatic send_quad(in_item_t it, bit typed, out_item_t typed_result);
    out_item_t pred;
    if (!quiet) begin
      while ($urandom_range(99) < 8) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (it.cmd == 1'(CMD_SEED)) begin
      gen_state = it.seed;
    end else begin
      pred = refine_quad(it);
      child_q.push_back(typed ? typed_result : pred);
    end
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (reg_idx_t'(idx))
      REG_PASS_MODE:    m_pass = value[0];
      REG_ODD_VARIANT:  m_odd  = value[0];
      REG_MIN_HEIGHT:   m_min  = value;
      REG_MAX_HEIGHT:   m_max  = value;
      REG_MESH_DIVISOR: m_div  = value;
      default: ;
    endcase
  endtask

  // Seed loads give no result, so the queue may be empty while work remains.
  task automatic drain();
    while (child_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Result side: check each transaction and apply random back-pressure.
  always @(posedge clk) begin
    out_item_t want;
    logic [63:0] g, w;
    string names[4];
    names = '{"child_tl", "child_tr", "child_bl", "child_br"};
    if (rst_n && out_valid && !out_stall) begin
      if (child_q.size() == 0) begin
        report_mismatch("unexpected result", out_data, 64'd0);
      end else begin
        want = child_q.pop_front();
        g = out_data;
        w = want;
        for (int k = 0; k < 4; k++) begin
          if (g[63 - 16 * k -: 16] !== w[63 - 16 * k -: 16])
            report_mismatch(names[k], g[63 - 16 * k -: 16], w[63 - 16 * k -: 16]);
        end
      end
    end
    out_stall <= quiet ? 1'b0 : ($urandom_range(99) < 8);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    quad_row_t rows[$];
    quad_row_t row;
    out_item_t none;
    out_item_t exp_val;
    logic [15:0] lo, hi, dv;
    int sent;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    err_count = 0;
    idle_cycles = 0;
    quiet = 1'b0;
    none = '0;
    gen_state = LcgReset;
    m_pass = 1'b0;
    m_odd = 1'b0;
    m_min = 16'd0;
    m_max = 16'hffff;
    m_div = 16'd200;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Flat quads of zero size get no displacement, so the result is the corner.
    row.item = make_quad(1'(CMD_REFINE), 0, 0, 0, 0, 0, 0, 0);
    row.typed = 1'b1;
    row.result = '0;
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0, 0);
    row.result = {4{16'hffff}};
    rows.push_back(row);
    row.typed = 1'b0;
    row.result = '0;
    row.item = make_quad(1'(CMD_REFINE), 0, 16'hffff, 0, 0, 16'hffff, 7'd64, 16'hffff);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 0, 16'hffff, 16'hffff, 0, 7'd127, 0);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_SEED), 32'h0, 16'h1234, 0, 0, 0, 7'd1, 0);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 16'h0010, 16'h0020, 16'h0030, 16'h0040, 7'd1, 0);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_SEED), 32'hffffffff, 0, 0, 0, 0, 0, 16'hffff);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 16'h8000, 16'h7fff, 16'h0001, 16'hfffe, 7'd3,
                         16'h5555);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 16'hfff0, 16'hfff0, 16'hfff0, 16'hfff0, 7'd64, 0);
    rows.push_back(row);
    row.item = make_quad(1'(CMD_REFINE), 0, 16'h0005, 16'h0005, 16'h0005, 16'h0005, 7'd32, 0);
    rows.push_back(row);
    for (int i = 0; i < rows.size(); i++)
      send_quad(rows[i].item, rows[i].typed, rows[i].result);

    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      in_valid <= 1'b0;
      drain();
      case (ph)
        0: begin lo = 16'd0; hi = 16'hffff; end
        1: begin lo = 16'($urandom_range(3000)); hi = 16'($urandom_range(62000, 65535)); end
        2: begin lo = 16'($urandom_range(40000, 65535)); hi = 16'($urandom_range(30000)); end
        3: begin lo = 16'hffff; hi = 16'd0; end
        4: begin lo = 16'($urandom_range(20000, 30000)); hi = lo + 16'd500; end
        5: begin lo = 16'd0; hi = 16'hffff; end
        6: begin lo = 16'($urandom); hi = lo; end
        default: begin lo = 16'($urandom_range(1000)); hi = 16'($urandom_range(50000, 65535)); end
      endcase
      case (ph)
        1: dv = 16'd0;
        3: dv = 16'd1;
        5: dv = 16'hffff;
        default: dv = 16'($urandom_range(1, 65535));
      endcase
      write_reg(3'(REG_PASS_MODE), 16'(ph % 2));
      write_reg(3'(REG_ODD_VARIANT), 16'((ph / 2) % 2));
      write_reg(3'(REG_MIN_HEIGHT), lo);
      write_reg(3'(REG_MAX_HEIGHT), hi);
      write_reg(3'(REG_MESH_DIVISOR), dv);
      if (ph == 0) begin
        // Indexes past the register list must leave every register alone.
        write_reg(3'd5, 16'($urandom));
        write_reg(3'd6, 16'hffff);
        write_reg(3'd7, 16'h0000);
      end
      cfg_valid <= 1'b0;
      @(posedge clk);

      send_quad(make_quad(1'(CMD_REFINE), 0, 0, 0, 0, 0, 7'd127, 16'hffff), 1'b0, none);
      send_quad(make_quad(1'(CMD_REFINE), 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 7'd64,
                          16'hffff), 1'b0, none);
      send_quad(make_quad(1'(CMD_REFINE), 0, 16'hffff, 0, 16'hffff, 0, 7'd0, 16'd0), 1'b0,
                none);
      for (int i = 0; i < PhaseItems; i++) begin
        quiet = (sent >= 300 && sent < 600);
        send_quad(rand_quad(), 1'b0, none);
        sent++;
      end
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    drain();
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/tqr_pkg.sv
rtl/tqr_divider.sv
rtl/tqr_front.sv
rtl/tqr_back.sv
rtl/terrain_quad_refine_unit.sv
tb/tb_terrain_quad_refine_unit.sv
